>>> hdl/glyph_text_to_pixel_rects_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text to pixel rects block
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_TO_PIXEL_RECTS_MACROS_SVH
`define GLYPH_TEXT_TO_PIXEL_RECTS_MACROS_SVH

// Property prop must hold at every edge outside reset.
`define GTPR_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gtpr assertion failed");

// When ante holds, cons must hold at the next edge.
`define GTPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtpr assertion failed");

`endif

>>> hdl/gtpr_pkg.sv
// ----------------------------------------------------------------------------
// gtpr_pkg
// Shared types, constants, font ROM and helper functions.
// ----------------------------------------------------------------------------
package gtpr_pkg;

    // field widths
    localparam int CODE_W      = 8;
    localparam int IN_COORD_W  = 16;
    localparam int OUT_COORD_W = 16;
    localparam int SCALE_W     = 7;
    localparam int COLOR_W     = 32;

    // internal coordinate range
    localparam int COORD_BITS  = 16;
    localparam int WIDE_W      = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int SUM_W       = WIDE_W + 2;

    localparam longint COORD_MAX_L = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN_L = -COORD_MAX_L - 1;
    localparam logic signed [SUM_W-1:0] SUM_COORD_MAX = SUM_W'(COORD_MAX_L);
    localparam logic signed [SUM_W-1:0] SUM_COORD_MIN = SUM_W'(COORD_MIN_L);

    // glyph geometry
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_CELLS   = GLYPH_ROWS * GLYPH_COLS;
    localparam int GLYPH_COUNT   = 42;
    localparam int GLYPH_IDX_W   = $clog2(GLYPH_COUNT);
    localparam int COL_W         = $clog2(GLYPH_COLS);
    localparam int ADVANCE_CELLS = 6;
    localparam int ADV_W         = SCALE_W + 3;

    // stream packing
    localparam int S_TDATA_BITS = CODE_W + 2 * IN_COORD_W + SCALE_W + COLOR_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 2 * OUT_COORD_W + SCALE_W + COLOR_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    localparam int S_CODE_LSB  = 0;
    localparam int S_OX_LSB    = S_CODE_LSB + CODE_W;
    localparam int S_OY_LSB    = S_OX_LSB + IN_COORD_W;
    localparam int S_SCALE_LSB = S_OY_LSB + IN_COORD_W;
    localparam int S_COLOR_LSB = S_SCALE_LSB + SCALE_W;

    // character codes
    localparam logic [CODE_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CODE_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CODE_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CODE_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CODE_W-1:0] CH_DIGIT_0  = 8'h30;
    localparam logic [CODE_W-1:0] CH_DIGIT_9  = 8'h39;
    localparam logic [CODE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CODE_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CODE_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [CODE_W-1:0] CH_PERIOD   = 8'h2E;
    localparam logic [CODE_W-1:0] CH_BANG     = 8'h21;
    localparam logic [CODE_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CODE_W-1:0] CASE_FOLD   = 8'h20;

    // ROM slots
    localparam logic [GLYPH_IDX_W-1:0] GI_DIGIT_0  = 6'd26;
    localparam logic [GLYPH_IDX_W-1:0] GI_SPACE    = 6'd36;
    localparam logic [GLYPH_IDX_W-1:0] GI_MINUS    = 6'd37;
    localparam logic [GLYPH_IDX_W-1:0] GI_COLON    = 6'd38;
    localparam logic [GLYPH_IDX_W-1:0] GI_PERIOD   = 6'd39;
    localparam logic [GLYPH_IDX_W-1:0] GI_BANG     = 6'd40;
    localparam logic [GLYPH_IDX_W-1:0] GI_QUESTION = 6'd41;

    // Row bit GLYPH_COLS-1 is the leftmost column.
    localparam logic [GLYPH_COLS-1:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{5'h04, 5'h0A, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h00}, // A
        '{5'h1E, 5'h11, 5'h1E, 5'h1E, 5'h11, 5'h1E, 5'h00}, // B
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F, 5'h00}, // C
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h00}, // D
        '{5'h1F, 5'h10, 5'h1E, 5'h1E, 5'h10, 5'h1F, 5'h00}, // E
        '{5'h1F, 5'h10, 5'h1E, 5'h1E, 5'h10, 5'h10, 5'h00}, // F
        '{5'h0F, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F, 5'h00}, // G
        '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h00}, // H
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00}, // I
        '{5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E, 5'h00}, // J
        '{5'h11, 5'h12, 5'h1C, 5'h1C, 5'h12, 5'h11, 5'h00}, // K
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F, 5'h00}, // L
        '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h00}, // M
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h00}, // N
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00}, // O
        '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10, 5'h00}, // P
        '{5'h0E, 5'h11, 5'h11, 5'h15, 5'h13, 5'h0F, 5'h00}, // Q
        '{5'h1E, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11, 5'h00}, // R
        '{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E, 5'h00}, // S
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00}, // T
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00}, // U
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h00}, // V
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11, 5'h00}, // W
        '{5'h11, 5'h0A, 5'h04, 5'h04, 5'h0A, 5'h11, 5'h00}, // X
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h00}, // Y
        '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F, 5'h00}, // Z
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}, // 0
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}, // 1
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F}, // 2
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E}, // 3
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}, // 4
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E}, // 5
        '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}, // 6
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10}, // 7
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}, // 8
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E}, // 9
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, // space
        '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00}, // minus
        '{5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00}, // colon
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00}, // period
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h00}, // bang
        '{5'h0E, 5'h11, 5'h02, 5'h04, 5'h00, 5'h04, 5'h00}  // question
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } gtpr_state_t;

    typedef struct packed {
        logic load;     // take the input transaction
        logic step;     // process one glyph cell
        logic advance;  // move the pen past the character
    } gtpr_cmd_t;

    typedef struct packed {
        logic glyph_done;  // no set cells left
        logic out_free;    // output register can take a square
    } gtpr_status_t;

    // Glyph as a cell vector, cell 0 (top left) in bit 0, row-major.
    // Codes without a glyph give all zeros.
    function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]      c;
        logic [GLYPH_IDX_W-1:0] idx;
        logic                   hit;
        logic [GLYPH_CELLS-1:0] bits;
        c   = code;
        idx = '0;
        hit = 1'b1;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_FOLD;
        priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            idx = GLYPH_IDX_W'(c - CH_UPPER_A);
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            idx = GI_DIGIT_0 + GLYPH_IDX_W'(c - CH_DIGIT_0);
        else if (c == CH_SPACE)
            idx = GI_SPACE;
        else if (c == CH_MINUS)
            idx = GI_MINUS;
        else if (c == CH_COLON)
            idx = GI_COLON;
        else if (c == CH_PERIOD)
            idx = GI_PERIOD;
        else if (c == CH_BANG)
            idx = GI_BANG;
        else if (c == CH_QUESTION)
            idx = GI_QUESTION;
        else
            hit = 1'b0;
        bits = '0;
        if (hit)
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                for (int k = 0; k < GLYPH_COLS; k++)
                begin
                    bits[r * GLYPH_COLS + k] = FONT_ROM[idx][r][GLYPH_COLS - 1 - k];
                end
            end
        end
        return bits;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        priority if (v > SUM_COORD_MAX)
            r = COORD_BITS'(COORD_MAX_L);
        else if (v < SUM_COORD_MIN)
            r = COORD_BITS'(COORD_MIN_L);
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

    // Low bits of the sign-extended coordinate.
    function automatic logic [OUT_COORD_W-1:0] out_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        logic signed [COORD_BITS+OUT_COORD_W-1:0] w;
        w = (COORD_BITS + OUT_COORD_W)'(v);
        return w[OUT_COORD_W-1:0];
    endfunction

endpackage

>>> hdl/glyph_text_to_pixel_rects.sv
// ----------------------------------------------------------------------------
// glyph_text_to_pixel_rects
// 5x7 character generator: one character in, one square per set font pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one character per transaction; master stream carries
//   one filled square per transaction, tlast on the last square of a glyph.
//   Lower case is folded to upper case. Unknown codes and the space give no
//   squares, but the pen still moves right by 6 * scale.
// Timing:
//   A character is taken in the idle state, then the 35 glyph cells are
//   walked one per cycle by the cell shifter while the output register is
//   free, stopping after the last set cell; then the pen is updated. A
//   square is in the output register in the cycle after its cell is walked,
//   so for cell 0 it follows the load and the first step of the scan.
// Reset:
//   Asynchronous, active low. Pen returns to 0, no square is pending.
// Backpressure:
//   A square waits in the output register; while it is not taken the cell
//   walk holds. A new character can still be accepted in the idle state.
// ----------------------------------------------------------------------------
module glyph_text_to_pixel_rects (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: char_code[7:0], origin_x[23:8], origin_y[39:24],
    //        pixel_scale[46:40], draw_color[78:47], zero pad[79]
    input  logic [gtpr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: start_of_text
    input  logic                           s_axis_tuser,
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: rect_x[15:0], rect_y[31:16], rect_size[38:32],
    //        rect_color[70:39], zero pad[71]
    output logic [gtpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tlast: last_of_glyph
    output logic                           m_axis_tlast
);

    gtpr_pkg::gtpr_cmd_t    cmd;
    gtpr_pkg::gtpr_status_t status;

    // sequencing: idle / scan
    gtpr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // glyph bits, coordinates, pen and output stage
    gtpr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/gtpr_ctrl.sv
// ----------------------------------------------------------------------------
// gtpr_ctrl
// Controller: accepts a character, sequences the cell scan, advances the pen.
// ----------------------------------------------------------------------------
module gtpr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  gtpr_pkg::gtpr_status_t status,
    output gtpr_pkg::gtpr_cmd_t    cmd
);

    gtpr_pkg::gtpr_state_t state_reg;
    gtpr_pkg::gtpr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gtpr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            gtpr_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gtpr_pkg::ST_SCAN;
                end
            end
            gtpr_pkg::ST_SCAN:
            begin
                priority if (status.glyph_done)
                begin
                    cmd.advance = 1'b1;
                    state_next  = gtpr_pkg::ST_IDLE;
                end
                else if (status.out_free)
                    cmd.step = 1'b1;
            end
            default:
                state_next = gtpr_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hdl/gtpr_datapath.sv
// ----------------------------------------------------------------------------
// gtpr_datapath
// Glyph cell shifter, coordinate accumulators, pen and output register.
// ----------------------------------------------------------------------------
module gtpr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gtpr_pkg::gtpr_cmd_t               cmd,
    output gtpr_pkg::gtpr_status_t            status,
    input  logic [gtpr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gtpr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int SUM_W   = gtpr_pkg::SUM_W;
    localparam int COORD_W = gtpr_pkg::COORD_BITS;
    localparam int SCALE_W = gtpr_pkg::SCALE_W;
    localparam int COLOR_W = gtpr_pkg::COLOR_W;
    localparam int CELLS   = gtpr_pkg::GLYPH_CELLS;
    localparam int COL_W   = gtpr_pkg::COL_W;
    localparam int IN_W    = gtpr_pkg::IN_COORD_W;
    localparam int PAD_W   = gtpr_pkg::M_TDATA_W - gtpr_pkg::M_TDATA_BITS;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(gtpr_pkg::GLYPH_COLS - 1);

    // input fields
    logic        [gtpr_pkg::CODE_W-1:0] in_code;
    logic signed [IN_W-1:0]             in_ox;
    logic signed [IN_W-1:0]             in_oy;
    logic        [SCALE_W-1:0]          in_scale;
    logic        [COLOR_W-1:0]          in_color;

    assign in_code  = s_axis_tdata[gtpr_pkg::S_CODE_LSB +: gtpr_pkg::CODE_W];
    assign in_ox    = s_axis_tdata[gtpr_pkg::S_OX_LSB +: IN_W];
    assign in_oy    = s_axis_tdata[gtpr_pkg::S_OY_LSB +: IN_W];
    assign in_scale = s_axis_tdata[gtpr_pkg::S_SCALE_LSB +: SCALE_W];
    assign in_color = s_axis_tdata[gtpr_pkg::S_COLOR_LSB +: COLOR_W];

    logic        [CELLS-1:0]   bits_reg,  bits_next;
    logic        [COL_W-1:0]   col_reg,   col_next;
    logic signed [SUM_W-1:0]   x_reg,     x_next;
    logic signed [SUM_W-1:0]   y_reg,     y_next;
    logic signed [COORD_W-1:0] pen_reg,   pen_next;
    logic        [SCALE_W-1:0] scale_reg, scale_next;
    logic        [COLOR_W-1:0] color_reg, color_next;
    logic                      out_valid_reg, out_valid_next;
    logic [gtpr_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                      out_last_reg,  out_last_next;

    logic signed [COORD_W-1:0] load_pen;
    logic signed [SUM_W-1:0]   pen_ext;
    logic signed [SUM_W-1:0]   scale_ext;
    logic        [gtpr_pkg::ADV_W-1:0] adv;
    logic signed [SUM_W-1:0]   adv_ext;

    assign load_pen  = s_axis_tuser ? gtpr_pkg::sat_coord(SUM_W'(in_ox)) : pen_reg;
    assign pen_ext   = SUM_W'(pen_reg);
    assign scale_ext = SUM_W'(scale_reg);
    // 6 * scale as two shifted copies
    assign adv       = gtpr_pkg::ADV_W'({scale_reg, 2'b00})
                     + gtpr_pkg::ADV_W'({scale_reg, 1'b0});
    assign adv_ext   = SUM_W'(adv);

    always_comb
    begin
        bits_next      = bits_reg;
        col_next       = col_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        pen_next       = pen_reg;
        scale_next     = scale_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            bits_next  = gtpr_pkg::glyph_bits(in_code);
            col_next   = '0;
            pen_next   = load_pen;
            x_next     = SUM_W'(load_pen);
            y_next     = SUM_W'(in_oy);
            scale_next = in_scale;
            color_next = in_color;
        end

        if (cmd.step)
        begin
            if (bits_reg[0])
            begin
                out_valid_next = 1'b1;
                out_data_next  = {{PAD_W{1'b0}}, color_reg, scale_reg,
                                  gtpr_pkg::out_coord(gtpr_pkg::sat_coord(y_reg)),
                                  gtpr_pkg::out_coord(gtpr_pkg::sat_coord(x_reg))};
                // last set cell when nothing remains above it
                out_last_next  = (bits_reg[CELLS-1:1] == '0);
            end
            bits_next = bits_reg >> 1;
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                x_next   = pen_ext;
                y_next   = y_reg + scale_ext;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                x_next   = x_reg + scale_ext;
            end
        end

        if (cmd.advance)
            pen_next = gtpr_pkg::sat_coord(pen_ext + adv_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_reg       <= pen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        col_reg      <= col_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        scale_reg    <= scale_next;
        color_reg    <= color_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign status.glyph_done = (bits_reg == '0);
    assign status.out_free   = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hdl/gtpr_checker.sv
// ----------------------------------------------------------------------------
// gtpr_checker
// Port-level checks on the character generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "glyph_text_to_pixel_rects_macros.svh"

module gtpr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [gtpr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gtpr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    logic                         in_take;
    logic                         out_take;
    logic                         out_stall;
    logic [gtpr_pkg::M_TDATA_W:0] out_word;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tdata};

    // stalled square holds
    `GTPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // one character at a time
    `GTPR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, !s_axis_tready)

    // squares still to come keep the input closed
    `GTPR_ASSERT_NEXT(a_busy_mid_glyph, clk, rst_n, out_take && !m_axis_tlast, !s_axis_tready)

    // when idle, only the closing square of a glyph can still be pending
    `GTPR_ASSERT_ALWAYS(a_idle_pending_last, clk, rst_n, s_axis_tready && m_axis_tvalid |-> m_axis_tlast)

endmodule

bind glyph_text_to_pixel_rects gtpr_checker u_gtpr_checker (.*);
